/* rtl/bsk_pkg.sv */
package bsk_pkg;

  localparam int KEY_W = 32;
  localparam int PRI_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int STATUS_W = 2;

  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

  localparam logic signed [PRI_W-1:0] WORST_INIT = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [PRI_W-1:0] pri;
  } entry_t;

endpackage

/* rtl/bsk_ifs.sv */
interface bsk_offer_if import bsk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [KEY_W-1:0]        new_key;
  logic signed [PRI_W-1:0] new_priority;
  logic [IDX_W-1:0]        read_index;

  modport source (output valid, mode, new_key, new_priority, read_index, input ready);
  modport sink   (input valid, mode, new_key, new_priority, read_index, output ready);
endinterface

interface bsk_result_if import bsk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [KEY_W-1:0]        entry_key;
  logic signed [PRI_W-1:0] entry_priority;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, entry_key, entry_priority, entry_count, input ready);
  modport sink   (input valid, status, entry_key, entry_priority, entry_count, output ready);
endinterface

/* rtl/bsk_store.sv */
module bsk_store import bsk_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/bounded_sorted_best_k_pool.sv */
// Sorted pool of the best POOL_SIZE (key, priority) entries, lower priority
// being better, priorities in signed Q16.16.
//
// Channels: "offer" carries requests (mode 0 offers new_key/new_priority,
// mode 1 reads the entry at read_index); "result" returns one answer per
// request with status, entry_key, entry_priority and entry_count.
//
// An offer that walks the list steps over the held entries in turn with the
// single compare-and-swap unit, which works on the entry memory through
// its one read and one write port, then finishes and emits. A rejected
// offer goes straight to the emit step; a read passes through a read step
// first. Only one request is in flight; offer.ready returns once the
// answer is loaded.
//
// The result sits in an output register, so a new request is taken while an
// earlier answer still waits; a stalled receiver holds the sequencer in its
// emit step until the register frees up.
//
// Reset (synchronous, rst high) empties the pool and sets the worst priority
// to the largest positive value; the entry memory is not cleared.
module bounded_sorted_best_k_pool import bsk_pkg::*; #(
  parameter int POOL_SIZE = 16
) (
  input  logic          clk,
  input  logic          rst,
  bsk_offer_if.sink     offer,
  bsk_result_if.source  result
);

  localparam int AW   = $clog2(POOL_SIZE);
  localparam int CW   = $clog2(POOL_SIZE + 1);
  localparam int CMPW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FINISH,
    S_READ,
    S_EMIT
  } state_t;

  state_t                  state;
  logic [CW-1:0]           held;
  logic signed [PRI_W-1:0] worst;
  logic [AW-1:0]           idx;
  entry_t                  carry;
  logic [KEY_W-1:0]        offer_key;
  logic                    placed;
  logic signed [PRI_W-1:0] last_pri;
  logic                    rd_ok;
  logic [STATUS_W-1:0]     res_status;
  entry_t                  res_entry;

  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  entry_t                  out_entry;
  logic [CNT_W-1:0]        out_count;

  logic                    accept;
  logic                    has_room;
  logic                    swap;
  logic                    last_step;
  logic [CMPW-1:0]         idx_inc;
  logic [AW+IDX_W-1:0]     idx_wide;
  logic [CW+IDX_W-1:0]     held_cmp;
  logic [CW+IDX_W-1:0]     read_cmp;
  logic [CW+CNT_W-1:0]     held_wide;
  logic                    idx_in_range;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  entry_t                  wr_data;
  logic [AW-1:0]           rd_addr;
  entry_t                  rd_data;

  bsk_store #(
    .DEPTH (POOL_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign offer.ready = (state == S_IDLE);
  assign accept      = offer.valid & offer.ready;

  assign has_room = (held < CW'(POOL_SIZE));

  // Read index is a fixed 4-bit field: widen it before narrowing to the
  // address and compare it against the count in a common width.
  assign idx_wide     = {{AW{1'b0}}, offer.read_index};
  assign held_cmp     = {{IDX_W{1'b0}}, held};
  assign read_cmp     = {{CW{1'b0}}, offer.read_index};
  assign idx_in_range = (read_cmp < held_cmp);
  assign held_wide    = {{CNT_W{1'b0}}, held};

  // Shared compare unit: the carried entry displaces the stored one when
  // the stored priority is strictly worse.
  assign swap      = (rd_data.pri > carry.pri);
  assign idx_inc   = {1'b0, idx} + CMPW'(1);
  assign last_step = (idx_inc == CMPW'(held));

  // Read address: entry 0 (or the read index) while idle, so the walk starts
  // with data in hand; during the walk prefetch the next entry.
  always_comb begin
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        rd_addr = (offer.mode == MODE_READ) ? idx_wide[AW-1:0] : '0;
      end
      S_WALK: begin
        rd_addr = idx_inc[AW-1:0];
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Single write port: swap back into the walked slot, or append at the end.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = carry;
    unique case (state)
      S_WALK: begin
        wr_en = swap;
      end
      S_FINISH: begin
        wr_en   = has_room;
        wr_addr = held[AW-1:0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      worst     <= WORST_INIT;
      out_valid <= 1'b0;
    end else begin
      // Drop the taken answer; the emit step does its own handoff.
      if (out_valid && result.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            carry.key <= offer.new_key;
            carry.pri <= offer.new_priority;
            offer_key <= offer.new_key;
            placed    <= 1'b0;
            idx       <= '0;
            res_entry <= '0;
            if (offer.mode == MODE_READ) begin
              rd_ok <= idx_in_range;
              state <= S_READ;
            end else if (!(has_room || worst >= offer.new_priority)) begin
              // Full and the offer is worse than the worst held: drop it.
              res_status <= ST_DROPPED;
              state      <= S_EMIT;
            end else if (held == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_WALK;
            end
          end
        end

        S_WALK: begin
          // Track the priority left at this slot; at the last step it is the
          // tail of the list.
          last_pri <= swap ? carry.pri : rd_data.pri;
          idx      <= idx_inc[AW-1:0];
          if (swap) begin
            carry  <= rd_data;
            placed <= 1'b1;
          end
          if (swap && rd_data.key == offer_key) begin
            // Older copy of this key pushed out: stop, leave worst stale.
            res_status <= ST_REPLACED;
            state      <= S_EMIT;
          end else if (last_step) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (has_room) begin
            held       <= held + CW'(1);
            worst      <= carry.pri;
            res_status <= ST_TAKEN;
          end else begin
            worst      <= last_pri;
            res_status <= placed ? ST_TAKEN : ST_DROPPED;
          end
          state <= S_EMIT;
        end

        S_READ: begin
          res_status <= ST_READ;
          res_entry  <= rd_ok ? rd_data : '0;
          state      <= S_EMIT;
        end

        S_EMIT: begin
          // Hold here until the output register is free.
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_entry  <= res_entry;
            out_count  <= held_wide[CNT_W-1:0];
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.entry_key      = out_entry.key;
  assign result.entry_priority = out_entry.pri;
  assign result.entry_count    = out_count;

endmodule

/* tb/bsk_pool_check_pkg.sv */
package bsk_pool_check_pkg;
  import bsk_pkg::*;

  localparam int POOL_DEPTH = 16;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic [KEY_W-1:0]        key;
    logic signed [PRI_W-1:0] pri;
    logic [CNT_W-1:0]        count;
  } pool_answer_t;

  // Shadow copy of the pool plus the queue of answers it predicts.
  class pool_answer_checker;
    logic [KEY_W-1:0]        keys [POOL_DEPTH];
    logic signed [PRI_W-1:0] pris [POOL_DEPTH];
    int unsigned             held;
    logic signed [PRI_W-1:0] worst;
    pool_answer_t            expected_answers[$];
    int                      failures;

    function new();
      held = 0;
      worst = WORST_INIT;
      failures = 0;
    endfunction

    // Walk the sorted list, swapping at each strictly worse entry.
    function logic [STATUS_W-1:0] apply_offer(logic [KEY_W-1:0] key,
                                              logic signed [PRI_W-1:0] pri);
      logic [KEY_W-1:0]        carry_key;
      logic signed [PRI_W-1:0] carry_pri;
      logic [KEY_W-1:0]        tk;
      logic signed [PRI_W-1:0] tp;
      bit                      placed;
      carry_key = key;
      carry_pri = pri;
      placed = 1'b0;
      if (!(held < POOL_DEPTH || worst >= pri)) return ST_DROPPED;
      for (int i = 0; i < held; i++) begin
        if (pris[i] > carry_pri) begin
          tk = keys[i];
          tp = pris[i];
          keys[i] = carry_key;
          pris[i] = carry_pri;
          carry_key = tk;
          carry_pri = tp;
          placed = 1'b1;
          // older copy of the same key falls out; worst stays stale
          if (carry_key == key) return ST_REPLACED;
        end
      end
      if (held < POOL_DEPTH) begin
        keys[held] = carry_key;
        pris[held] = carry_pri;
        held++;
        placed = 1'b1;
      end
      if (held > 0) worst = pris[held-1];
      return placed ? ST_TAKEN : ST_DROPPED;
    endfunction

    function void note_request(logic mode, logic [KEY_W-1:0] key,
                               logic signed [PRI_W-1:0] pri, logic [IDX_W-1:0] idx);
      pool_answer_t a;
      a.key = '0;
      a.pri = '0;
      if (mode == MODE_OFFER) begin
        a.status = apply_offer(key, pri);
      end else begin
        a.status = ST_READ;
        if (idx < held) begin
          a.key = keys[idx];
          a.pri = pris[idx];
        end
      end
      a.count = held[CNT_W-1:0];
      expected_answers.insert(expected_answers.size(), a);
    endfunction

    function void check_answer(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                               logic signed [PRI_W-1:0] pri, logic [CNT_W-1:0] count);
      pool_answer_t a;
      if (expected_answers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected answer: st=%0d key=%h pri=%h cnt=%0d",
                   status, key, pri, count);
        return;
      end
      a = expected_answers.pop_front();
      if (status !== a.status || key !== a.key || pri !== a.pri || count !== a.count) begin
        failures++;
        if (failures <= 10)
          $display({"answer mismatch: exp st=%0d key=%h pri=%h cnt=%0d, ",
                    "got st=%0d key=%h pri=%h cnt=%0d"},
                   a.status, a.key, a.pri, a.count, status, key, pri, count);
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function void close_out();
      if (expected_answers.size() != 0) begin
        failures++;
        $display("%0d answers never arrived", expected_answers.size());
      end
    endfunction
  endclass

endpackage

/* tb/bounded_sorted_best_k_pool_tb.sv */
module bounded_sorted_best_k_pool_tb;
  import bsk_pkg::*;
  import bsk_pool_check_pkg::*;

  logic clk;
  logic rst;

  bsk_offer_if  offer_ch();
  bsk_result_if result_ch();

  bounded_sorted_best_k_pool #(.POOL_SIZE(POOL_DEPTH)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .offer  (offer_ch),
    .result (result_ch)
  );

  pool_answer_checker pool_sb = new();

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sender idling comes and goes in stretches so that some runs of requests
  // arrive back to back and others with idle gaps between them.
  bit send_idles = 1'b1;

  // Saturate a wide value into the Q16.16 range.
  function automatic logic signed [PRI_W-1:0] to_q16(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[PRI_W-1:0];
  endfunction

  // Aim most priorities where the pool is contested: near the current worst
  // entry or near a stored one, so swaps, drops and duplicate hits happen
  // even once the pool is full. Keep a share of wide-open values and extremes.
  function automatic logic signed [PRI_W-1:0] pick_priority();
    int unsigned roll;
    int unsigned j;
    roll = $urandom_range(0, 99);
    if (roll < 45)
      return to_q16(longint'(pool_sb.worst) + longint'($urandom_range(0, 16)) - 8);
    if (roll < 70 && pool_sb.held > 0) begin
      j = $urandom_range(0, pool_sb.held - 1);
      return to_q16(longint'(pool_sb.pris[j]) + longint'($urandom_range(0, 4)) - 2);
    end
    if (roll < 82) return $urandom();
    if (roll < 88) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return to_q16(longint'($urandom_range(0, 40)) - 20);
  endfunction

  // Reuse stored keys often so the duplicate-removal path gets exercised.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && pool_sb.held > 0)
      return pool_sb.keys[$urandom_range(0, pool_sb.held - 1)];
    if (roll < 80) return $urandom_range(0, 31);
    return $urandom();
  endfunction

  // Drive one request, hold it until the block takes it, then log it.
  task automatic send_request(logic mode, logic [KEY_W-1:0] key,
                              logic signed [PRI_W-1:0] pri, logic [IDX_W-1:0] idx);
    int gap;
    if ($urandom_range(0, 29) == 0) send_idles = !send_idles;
    gap = send_idles ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      offer_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offer_ch.valid        <= 1'b1;
    offer_ch.mode         <= mode;
    offer_ch.new_key      <= key;
    offer_ch.new_priority <= pri;
    offer_ch.read_index   <= idx;
    @(posedge clk);
    while (!offer_ch.ready) @(posedge clk);
    pool_sb.note_request(mode, key, pri, idx);
  endtask

  task automatic run_directed();
    // empty pool: reads fall out of range
    send_request(MODE_READ, '0, '0, 4'd0);
    send_request(MODE_OFFER, 32'h0000_0000, 32'sh7FFF_FFFF, '0);
    send_request(MODE_OFFER, 32'hFFFF_FFFF, 32'sh8000_0000, '0);
    // same key, same priority: not seen as a duplicate
    send_request(MODE_OFFER, 32'hFFFF_FFFF, 32'sh8000_0000, '0);
    send_request(MODE_READ, '0, '0, 4'd15);
    // fill the pool to capacity
    for (int k = 1; k <= 13; k++)
      send_request(MODE_OFFER, k, to_q16(longint'(k) * 65536), '0);
    // full, ties with the worst entry: considered, then dropped
    send_request(MODE_OFFER, 32'd100, 32'sh7FFF_FFFF, '0);
    // better copy of a stored key pushes the older copy out, worst goes stale
    send_request(MODE_OFFER, 32'd5, -32'sd5, '0);
    send_request(MODE_READ, '0, '0, 4'd15);
    send_request(MODE_READ, '0, '0, 4'd3);
    // full, new entry pushes the last one out
    send_request(MODE_OFFER, 32'd200, 32'sd1, '0);
    // full, worse than the worst: rejected outright
    send_request(MODE_OFFER, 32'd201, 32'sh7FFF_FFFF, '0);
  endtask

  task automatic run_random(int n);
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      idx = $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 20)
        send_request(MODE_READ, $urandom(), $urandom(), idx);
      else
        send_request(MODE_OFFER, pick_key(), pick_priority(), idx);
    end
  endtask

  // Result side: stall at random, in stretches, and check every answer taken.
  initial begin
    bit take_idles;
    int gap;
    take_idles = 1'b1;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) take_idles = !take_idles;
      gap = take_idles ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      pool_sb.check_answer(result_ch.status, result_ch.entry_key,
                           result_ch.entry_priority, result_ch.entry_count);
    end
  end

  // Main sequence: reset, directed requests, random requests, drain.
  initial begin
    rst                   <= 1'b1;
    offer_ch.valid        <= 1'b0;
    offer_ch.mode         <= MODE_OFFER;
    offer_ch.new_key      <= '0;
    offer_ch.new_priority <= '0;
    offer_ch.read_index   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(600);
    offer_ch.valid <= 1'b0;
    while (pool_sb.pending() != 0) @(posedge clk);
    // allow for a late, unexpected answer before closing out
    repeat (30) @(posedge clk);
    pool_sb.close_out();
    if (pool_sb.failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Timeout: well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/bsk_pkg.sv
rtl/bsk_ifs.sv
rtl/bsk_store.sv
rtl/bounded_sorted_best_k_pool.sv
tb/bsk_pool_check_pkg.sv
tb/bounded_sorted_best_k_pool_tb.sv
